// File: hdl/qcr_pkg.sv
// Package for the quadrature counter with speed measurement.
// Holds the sequencer state type, the item kind codes and the fixed arithmetic constants.
// No dependencies.
package qcr_pkg;

	// Sequencer states of the speed datapath.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_DONE
	} qcr_state_t;

	// Item kind codes. The fourth code changes nothing.
	localparam logic [1:0] KIND_EDGE_A = 2'd0;
	localparam logic [1:0] KIND_EDGE_B = 2'd1;
	localparam logic [1:0] KIND_SPEED  = 2'd2;

	localparam int TIME_W = 32;
	localparam int CPR_W  = 16;
	localparam int DEN_W  = CPR_W + TIME_W;
	localparam int SPD_W  = 32;

	// Milliseconds per minute, consumed one bit per cycle by the scaler.
	localparam int MUL_STEPS = 16;
	localparam logic [MUL_STEPS-1:0] MS_PER_MINUTE = 16'd60000;

	localparam logic [CPR_W-1:0] CPR_RESET = 16'd1024;
	localparam logic [SPD_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
	localparam logic [SPD_W-1:0] SPEED_MIN = 32'h8000_0000;

endpackage

// File: hdl/quadrature_counter_with_rpm.sv
// Top level of the quadrature counter with speed measurement in RPM.
// Depends on qcr_pkg; holds the edge counter, the bit-serial speed datapath
// and the output register.
//
// Usage notes
// -----------
// Input channel (in_valid / in_ready) carries one beat per event: an edge on
// channel A, an edge on channel B, or a speed request stamped with time_ms.
// Every input beat produces exactly one output beat (out_valid / out_ready)
// with the position after the event and the last computed speed.
// Edge beats pass through the DONE state: the count moves at acceptance and the result
// is loaded into the output register once that register is free, so a new edge is taken
// only after the previous result has been loaded.
// A speed request runs from acceptance to the output beat through a preparation step,
// shift-and-add steps scaling the count difference by 60000, a restoring divider that
// consumes one numerator bit per cycle, and a saturation step. A request with zero
// elapsed time (or zero resolution) skips the arithmetic and goes straight to the
// DONE state like an edge.
// The output register separates the two channels: a new beat is accepted
// while a finished result still waits for out_ready; the next result then
// waits inside the block until the output register empties.
// The user writes counts_per_rev through cfg_we / cfg_data only while the block is idle;
// the block itself does not enforce this. Reset clears the count, the speed reference,
// the last speed, and sets the resolution to 1024 counts per revolution.
module quadrature_counter_with_rpm #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              kind,
	input  logic                    level_a,
	input  logic                    level_b,
	input  logic [31:0]             time_ms,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [31:0]      position,
	output logic signed [31:0]      speed_rpm,
	output logic                    speed_valid,
	output logic                    zero_interval
);

	// The scaled numerator is the count magnitude times a 16-bit constant.
	localparam int NW = COUNT_WIDTH + qcr_pkg::MUL_STEPS;
	localparam int SW = $clog2(NW);
	localparam int MW = $clog2(qcr_pkg::MUL_STEPS);
	localparam int DW = qcr_pkg::DEN_W;
	localparam int QW = qcr_pkg::SPD_W;

	qcr_pkg::qcr_state_t state_q, state_d;

	// Architectural state.
	logic [COUNT_WIDTH-1:0]       count_q;
	logic [COUNT_WIDTH-1:0]       count_ref_q;
	logic [qcr_pkg::TIME_W-1:0]   time_ref_q;
	logic [QW-1:0]                speed_q;
	logic [qcr_pkg::CPR_W-1:0]    cpr_q;

	// Speed datapath.
	logic [COUNT_WIDTH-1:0]       dp_q;
	logic [qcr_pkg::TIME_W-1:0]   dt_q;
	logic [COUNT_WIDTH-1:0]       mag_q;
	logic                         neg_q;
	logic [DW-1:0]                den_q;
	logic [NW-1:0]                num_q;
	logic [DW-1:0]                rem_q;
	logic [QW-1:0]                quo_q;
	logic                         ovf_q;
	logic [SW-1:0]                step_q;
	logic                         sv_q;
	logic                         zero_q;

	// Output register.
	logic                         out_valid_q;
	logic [31:0]                  position_q;
	logic [QW-1:0]                speed_rpm_q;
	logic                         speed_valid_q;
	logic                         zero_interval_q;

	logic                         in_accept;
	logic                         out_load;
	logic                         is_edge;
	logic                         dir_up;
	logic                         dt_zero;
	logic                         skip_div;
	logic [DW:0]                  trial;
	logic [DW:0]                  diff;
	logic                         trial_ge;
	logic [QW-1:0]                speed_sat;
	logic signed [COUNT_WIDTH-1:0] count_s;

	assign in_accept = in_valid & in_ready;
	assign is_edge   = (kind == qcr_pkg::KIND_EDGE_A) || (kind == qcr_pkg::KIND_EDGE_B);
	// Channel A counts up on equal levels, channel B on differing levels.
	assign dir_up    = (kind == qcr_pkg::KIND_EDGE_A) ? (level_a == level_b)
	                                                  : (level_a != level_b);
	assign dt_zero   = (time_ms == time_ref_q);
	assign skip_div  = dt_zero || (cpr_q == '0);
	assign count_s   = count_q;

	// One restoring division step: bring down the next numerator bit.
	assign trial    = {rem_q, num_q[NW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign trial_ge = (trial >= {1'b0, den_q});

	// Clamp the magnitude to the signed 32-bit range and apply the sign.
	always_comb begin
		if (!neg_q) begin
			speed_sat = (ovf_q || quo_q[QW-1]) ? qcr_pkg::SPEED_MAX : quo_q;
		end else begin
			speed_sat = (ovf_q || (quo_q > qcr_pkg::SPEED_MIN)) ? qcr_pkg::SPEED_MIN
			                                                    : (~quo_q + QW'(1));
		end
	end

	// Sequencer: next state and handshake.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			qcr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if ((kind == qcr_pkg::KIND_SPEED) && !skip_div) begin
						state_d = qcr_pkg::ST_PREP;
					end else begin
						state_d = qcr_pkg::ST_DONE;
					end
				end
			end
			qcr_pkg::ST_PREP: begin
				state_d = qcr_pkg::ST_MUL;
			end
			qcr_pkg::ST_MUL: begin
				if (step_q == '0) begin
					state_d = qcr_pkg::ST_DIV;
				end
			end
			qcr_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_d = qcr_pkg::ST_SAT;
				end
			end
			qcr_pkg::ST_SAT: begin
				state_d = qcr_pkg::ST_DONE;
			end
			qcr_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = qcr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qcr_pkg::ST_IDLE;
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qcr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cpr_q       <= qcr_pkg::CPR_RESET;
			count_q     <= '0;
			count_ref_q <= '0;
			time_ref_q  <= '0;
			speed_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cpr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_accept) begin
				if (is_edge) begin
					count_q <= dir_up ? count_q + COUNT_WIDTH'(1) : count_q - COUNT_WIDTH'(1);
				end
				if (kind == qcr_pkg::KIND_SPEED) begin
					count_ref_q <= count_q;
					time_ref_q  <= time_ms;
					if (skip_div) begin
						speed_q <= '0;
					end
				end
			end
			if (state_q == qcr_pkg::ST_SAT) begin
				speed_q <= speed_sat;
			end
		end
	end

	// Speed datapath registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sv_q   <= (kind == qcr_pkg::KIND_SPEED);
			zero_q <= (kind == qcr_pkg::KIND_SPEED) && dt_zero;
			dp_q   <= count_q - count_ref_q;
			dt_q   <= time_ms - time_ref_q;
		end
		unique case (state_q)
			qcr_pkg::ST_PREP: begin
				neg_q  <= dp_q[COUNT_WIDTH-1];
				mag_q  <= dp_q[COUNT_WIDTH-1] ? (~dp_q + COUNT_WIDTH'(1)) : dp_q;
				den_q  <= DW'(cpr_q) * DW'(dt_q);
				num_q  <= '0;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				step_q <= SW'(qcr_pkg::MUL_STEPS - 1);
			end
			qcr_pkg::ST_MUL: begin
				// Horner scaling by 60000, most significant constant bit first.
				num_q <= {num_q[NW-2:0], 1'b0}
				       + (qcr_pkg::MS_PER_MINUTE[step_q[MW-1:0]] ? NW'(mag_q) : '0);
				if (step_q == '0) begin
					step_q <= SW'(NW - 1);
				end else begin
					step_q <= step_q - SW'(1);
				end
			end
			qcr_pkg::ST_DIV: begin
				num_q  <= {num_q[NW-2:0], 1'b0};
				rem_q  <= trial_ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_q  <= {quo_q[QW-2:0], trial_ge};
				// A quotient bit pushed out of the top means the speed saturates.
				ovf_q  <= ovf_q | quo_q[QW-1];
				step_q <= step_q - SW'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			position_q      <= 32'(count_s);
			speed_rpm_q     <= speed_q;
			speed_valid_q   <= sv_q;
			zero_interval_q <= zero_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign position      = position_q;
	assign speed_rpm     = speed_rpm_q;
	assign speed_valid   = speed_valid_q;
	assign zero_interval = zero_interval_q;

endmodule

// File: hdl/qcr_checker.sv
// Port-level checker for the quadrature counter with speed measurement.
// Depends on qcr_pkg; bound to quadrature_counter_with_rpm at the end of this file.
module qcr_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [15:0] cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  kind,
	input logic        level_a,
	input logic        level_b,
	input logic [31:0] time_ms,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] position,
	input logic [31:0] speed_rpm,
	input logic        speed_valid,
	input logic        zero_interval
);

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position) && $stable(speed_rpm))
		else $error("output beat changed while stalled");

	// The block leaves the idle state on every accepted beat, so in_ready drops after each acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on two consecutive cycles");

	// A zero interval is only reported on a speed answer and forces zero speed.
	a_zero_interval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_interval |-> speed_valid && (speed_rpm == 32'd0))
		else $error("zero interval flagged with non-zero speed or on an edge beat");

	// An edge beat into an empty output passes DONE and appears without speed flag.
	a_edge_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid &&
		((kind == qcr_pkg::KIND_EDGE_A) || (kind == qcr_pkg::KIND_EDGE_B))
		|=> ##1 out_valid && !speed_valid)
		else $error("edge beat result missing or flagged as speed");

endmodule

bind quadrature_counter_with_rpm qcr_port_checks u_qcr_port_checks (.*);
